### src/smt_pkg.sv
package smt_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int VALUE_W = 32;
	localparam int KIND_W = 2;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COUNT = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

endpackage

### src/smt_if.sv
interface smt_req_if;
	logic valid;
	logic ready;
	logic [smt_pkg::KIND_W-1:0] kind;
	logic signed [smt_pkg::VALUE_W-1:0] value;

	modport source(output valid, output kind, output value, input ready);
	modport sink(input valid, input kind, input value, output ready);
endinterface

interface smt_rsp_if #(
	parameter int CNT_W = $clog2(smt_pkg::CAPACITY_DEF + 1)
);
	logic valid;
	logic ready;
	logic [smt_pkg::STATUS_W-1:0] status;
	logic [CNT_W-1:0] match_count;
	logic [CNT_W-1:0] occupancy;

	modport source(output valid, output status, output match_count, output occupancy,
		input ready);
	modport sink(input valid, input status, input match_count, input occupancy,
		output ready);
endinterface

### src/smt_mem.sv
module smt_mem #(
	parameter int DEPTH = smt_pkg::CAPACITY_DEF,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic signed [smt_pkg::VALUE_W-1:0] wdata,
	input  logic [AW-1:0]                     raddr,
	output logic signed [smt_pkg::VALUE_W-1:0] rdata
);

	logic signed [smt_pkg::VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/smt_ctrl.sv
module smt_ctrl #(
	parameter int CAPACITY = smt_pkg::CAPACITY_DEF,
	parameter int CNT_W = $clog2(CAPACITY + 1),
	parameter int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	smt_req_if.sink                            req,
	smt_rsp_if.source                          rsp,
	output logic                               mem_we,
	output logic [IDX_W-1:0]                   mem_waddr,
	output logic signed [smt_pkg::VALUE_W-1:0] mem_wdata,
	output logic [IDX_W-1:0]                   mem_raddr,
	input  logic signed [smt_pkg::VALUE_W-1:0] mem_rdata
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	state_t state_q;
	logic [smt_pkg::KIND_W-1:0] kind_q;
	logic signed [smt_pkg::VALUE_W-1:0] value_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] match_q;
	logic [smt_pkg::STATUS_W-1:0] status_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] last_q;
	logic issuing_q;
	logic found_q;
	logic head_q;
	logic rd_pend_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic rsp_valid_q;
	logic [smt_pkg::STATUS_W-1:0] rsp_status_q;
	logic [CNT_W-1:0] rsp_match_q;
	logic [CNT_W-1:0] rsp_occ_q;

	logic start;
	logic finish;
	logic set_head;
	logic set_found;
	logic match_inc;
	logic cnt_inc;
	logic cnt_dec;
	logic not_found;
	logic eq;
	logic gt;
	logic issue_last;
	logic load_rsp;
	logic [CNT_W-1:0] cnt_m1;

	assign req.ready = (state_q == ST_IDLE);
	assign start = req.valid && req.ready;
	assign eq = (mem_rdata == value_q);
	assign gt = (mem_rdata > value_q);
	assign cnt_m1 = cnt_q - 1'b1;
	assign mem_raddr = idx_q;
	assign issue_last = (kind_q == smt_pkg::KIND_INSERT) ? (idx_q == '0) : (idx_q == last_q);
	assign load_rsp = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = value_q;
		finish = 1'b0;
		set_head = 1'b0;
		set_found = 1'b0;
		match_inc = 1'b0;
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		not_found = 1'b0;
		if (start) begin
			if (req.kind == smt_pkg::KIND_INSERT && cnt_q == '0) begin
				mem_we = 1'b1;
				mem_wdata = req.value;
			end
		end else if (state_q == ST_RUN) begin
			case (kind_q)
				smt_pkg::KIND_INSERT: begin
					if (head_q) begin
						mem_we = 1'b1;
						finish = 1'b1;
						cnt_inc = 1'b1;
					end else if (rd_pend_s1) begin
						mem_we = 1'b1;
						mem_waddr = rd_idx_s1 + 1'b1;
						if (gt) begin
							mem_wdata = mem_rdata;
							set_head = (rd_idx_s1 == '0);
						end else begin
							finish = 1'b1;
							cnt_inc = 1'b1;
						end
					end
				end
				smt_pkg::KIND_DELETE: begin
					if (rd_pend_s1) begin
						if (found_q) begin
							mem_we = 1'b1;
							mem_waddr = rd_idx_s1 - 1'b1;
							mem_wdata = mem_rdata;
						end else if (eq) begin
							set_found = 1'b1;
						end
						if (rd_idx_s1 == last_q) begin
							finish = 1'b1;
							cnt_dec = found_q || eq;
							not_found = !(found_q || eq);
						end
					end
				end
				default: begin
					if (rd_pend_s1) begin
						match_inc = eq;
						finish = (rd_idx_s1 == last_q);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			issuing_q <= 1'b0;
			rd_pend_s1 <= 1'b0;
			head_q <= 1'b0;
			found_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= (state_q == ST_RUN) && issuing_q && !finish;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						head_q <= 1'b0;
						found_q <= 1'b0;
						issuing_q <= 1'b1;
						if (req.kind == smt_pkg::KIND_INSERT) begin
							if (cnt_q == CAP_CNT) begin
								state_q <= ST_DONE;
							end else if (cnt_q == '0) begin
								cnt_q <= cnt_q + 1'b1;
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_RUN;
							end
						end else if (req.kind inside {smt_pkg::KIND_DELETE,
								smt_pkg::KIND_COUNT}) begin
							state_q <= (cnt_q == '0) ? ST_DONE : ST_RUN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RUN: begin
					if (set_head) begin
						head_q <= 1'b1;
					end
					if (set_found) begin
						found_q <= 1'b1;
					end
					if (issuing_q && issue_last && !finish) begin
						issuing_q <= 1'b0;
					end
					if (cnt_inc) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (cnt_dec) begin
						cnt_q <= cnt_q - 1'b1;
					end
					if (finish) begin
						issuing_q <= 1'b0;
						head_q <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (start) begin
			kind_q <= req.kind;
			value_q <= req.value;
			match_q <= '0;
			last_q <= IDX_W'(cnt_m1);
			idx_q <= (req.kind == smt_pkg::KIND_INSERT) ? IDX_W'(cnt_m1) : '0;
			if (req.kind == smt_pkg::KIND_INSERT && cnt_q == CAP_CNT) begin
				status_q <= smt_pkg::STATUS_FULL;
			end else if (req.kind == smt_pkg::KIND_DELETE && cnt_q == '0) begin
				status_q <= smt_pkg::STATUS_NOT_FOUND;
			end else begin
				status_q <= smt_pkg::STATUS_DONE;
			end
		end else if (state_q == ST_RUN) begin
			if (issuing_q && !issue_last) begin
				idx_q <= (kind_q == smt_pkg::KIND_INSERT) ? idx_q - 1'b1 : idx_q + 1'b1;
			end
			if (match_inc) begin
				match_q <= match_q + 1'b1;
			end
			if (not_found) begin
				status_q <= smt_pkg::STATUS_NOT_FOUND;
			end
		end
		if (load_rsp) begin
			rsp_status_q <= status_q;
			rsp_match_q <= (kind_q == smt_pkg::KIND_COUNT) ? match_q : '0;
			rsp_occ_q <= cnt_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.match_count = rsp_match_q;
	assign rsp.occupancy = rsp_occ_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_CNT)
		else $error("entry count above capacity");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) && !start |-> !mem_we)
		else $error("memory write outside of an operation");

	a_read_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> $past(state_q) == ST_RUN)
		else $error("read data pending without an active operation");

	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CNT_W + 1)'(mem_waddr) < (CNT_W + 1)'(cnt_q) + 1'b1)
		else $error("write beyond occupied region");

endmodule

### src/sorted_multiset_table.sv
// An accepted beat goes straight to the result beat on an empty table, for a
// full-table insert or an unused kind; a delete or a search walks all n stored
// entries one per cycle, and an insert walks down from the top and shifts each
// larger entry up one slot, so all n entries for an insert at the head.
// Throughput: one request at a time; the next beat is taken at the earliest result edge.
// Reset clears the occupancy and control state; memory contents are left as is.
module sorted_multiset_table #(
	parameter int CAPACITY = smt_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	smt_req_if.sink   req,
	smt_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic signed [smt_pkg::VALUE_W-1:0] mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	logic signed [smt_pkg::VALUE_W-1:0] mem_rdata;

	smt_mem #(
		.DEPTH(CAPACITY),
		.AW(IDX_W)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	smt_ctrl #(
		.CAPACITY(CAPACITY),
		.CNT_W(CNT_W),
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

endmodule
